// ===== hdl/table_interp_sine_cosine_tangent_core_assert.svh =====
// assertion macros for the table interpolation trig core
`ifndef TABLE_INTERP_SINE_COSINE_TANGENT_CORE_ASSERT_SVH
`define TABLE_INTERP_SINE_COSINE_TANGENT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TISCT_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("tisct assertion failed");

`define TISCT_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("tisct assertion failed");

`else

`define TISCT_ASSERT_IMPL(name, clock, resetn, ante, cons)

`define TISCT_ASSERT_NEXT(name, clock, resetn, ante, cons)

`endif

`endif

// ===== hdl/tisct_pkg.sv =====
`default_nettype none

package tisct_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int FRACTION_BITS = 16;
    localparam int TABLE_BITS = $clog2(TABLE_ENTRIES);
    localparam int ROM_ADDR_W = TABLE_BITS + 1;

    localparam int ANGLE_W = 32;
    localparam int MAG_W = 32;
    localparam int COEF_W = 64;
    localparam int HALF_W = 32;
    localparam int PART_W = MAG_W + HALF_W;
    localparam int PROD_W = MAG_W + COEF_W;
    localparam int POS_SHIFT = 90 - FRACTION_BITS - TABLE_BITS;
    localparam int POS_W = PROD_W - POS_SHIFT;

    localparam int VAL_W = 31;
    localparam int OUT_W = 32;
    localparam int TAN_FRAC = 15;
    localparam int QUO_W = 31;

    localparam logic [COEF_W-1:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_1529;
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921_FB54_442D_1846;
    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic signed [ANGLE_W:0] PI_HALF_Q26 = 33'sd105414357;
    localparam logic signed [OUT_W-1:0] TAN_MAX = 32'sh7FFF_FFFF;

    localparam logic [63:0] ROM_STEP = PI_HALF_Q60 / TABLE_ENTRIES;
    localparam logic [63:0] ROM_REM = PI_HALF_Q60 % TABLE_ENTRIES;

    typedef logic [VAL_W-1:0] cos_rom_t [TABLE_ENTRIES+1];

    typedef struct packed {
        logic [VAL_W-1:0] mag_c;
        logic             neg_c;
        logic [VAL_W-1:0] mag_s;
        logic             neg_s;
    } trig_t;

    // elaboration only: shift and subtract quotient
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // elaboration only: taylor series in q.60, rounded to q1.30
    function automatic logic [VAL_W-1:0] cos_entry(input logic [63:0] x);
        logic [127:0]      wide;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        logic [63:0]       r;
        wide = {64'd0, x} * {64'd0, x};
        x2 = wide[123:60];
        term = ONE_Q60;
        sum = $signed(ONE_Q60);
        for (int k = 1; k < 40; k++)
        begin
            if (term != 64'd0)
            begin
                wide = {64'd0, term} * {64'd0, x2};
                term = div_u64(wide[123:60], 64'(2 * k - 1) * 64'(2 * k));
                if (k[0])
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
        end
        if (sum <= 0)
        begin
            r = 64'd0;
        end
        else
        begin
            r = ($unsigned(sum) + (64'd1 << 29)) >> 30;
            if (r > (64'd1 << 30))
            begin
                r = 64'd1 << 30;
            end
        end
        return r[VAL_W-1:0];
    endfunction

    function automatic cos_rom_t build_rom();
        cos_rom_t    rom;
        logic [63:0] x;
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            x = ROM_STEP * 64'(i) + ((ROM_REM * 64'(i)) >> TABLE_BITS);
            rom[i] = cos_entry(x);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_rom();

endpackage

`default_nettype wire

// ===== hdl/tisct_in_if.sv =====
`default_nettype none

interface tisct_in_if;
    import tisct_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

`default_nettype wire

// ===== hdl/tisct_out_if.sv =====
`default_nettype none

interface tisct_out_if;
    import tisct_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cosine;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] tangent;
    logic                    tangent_saturated;

    modport source (output valid, output cosine, output sine, output tangent,
                    output tangent_saturated, input ready);
    modport sink (input valid, input cosine, input sine, input tangent,
                  input tangent_saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/table_interp_sine_cosine_tangent_core.sv =====
// Cosine, sine and tangent of a signed Q5.26 angle in radians, all three on every
// transfer. The angle is scaled to a position in a 33-entry quarter-wave cosine
// table, folded by quadrant and interpolated linearly; sine uses the angle minus
// pi/2. Tangent is sine/cosine in Q16.15, truncated toward zero and clipped to
// +-(2^31-1), with tangent_saturated set on a clip or a zero cosine. One angle is
// accepted per cycle unless the result side stalls. Of the stages, 5 form the
// table position, 3 interpolate, and a restoring divider spends one stage per
// quotient bit (31) plus a setup stage and the output register.
// A stall on the result side freezes the pipeline; the input register can still
// take one more angle while it waits. The table is a constant, with no fill time.
`default_nettype none
`include "table_interp_sine_cosine_tangent_core_assert.svh"

module table_interp_sine_cosine_tangent_core (
    input  logic              clk,
    input  logic              rst_n,
    tisct_in_if.sink          sample,
    tisct_out_if.source       result
);
    import tisct_pkg::*;

    logic                    adv;
    logic                    pos_valid;
    logic [1:0][POS_W-1:0]   pos;
    logic                    trig_valid;
    trig_t                   trig;
    logic                    out_valid;

    assign adv = !out_valid || result.ready;

    tisct_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .angle     (sample.angle),
        .out_valid (pos_valid),
        .pos       (pos)
    );

    tisct_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pos_valid),
        .pos       (pos),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    tisct_divide u_divide (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (trig_valid),
        .trig              (trig),
        .out_valid         (out_valid),
        .cosine            (result.cosine),
        .sine              (result.sine),
        .tangent           (result.tangent),
        .tangent_saturated (result.tangent_saturated)
    );

    assign result.valid = out_valid;

    `TISCT_ASSERT_IMPL(sat_at_limit, clk, rst_n, result.valid && result.tangent_saturated, result.tangent == TAN_MAX || result.tangent == -TAN_MAX)
    `TISCT_ASSERT_IMPL(zero_cos_sat, clk, rst_n, result.valid && result.cosine == '0, result.tangent_saturated)
    `TISCT_ASSERT_IMPL(zero_sin_tan, clk, rst_n, result.valid && !result.tangent_saturated && result.sine == '0, result.tangent == '0)

endmodule

`default_nettype wire

// ===== hdl/tisct_position.sv =====
`default_nettype none

module tisct_position (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tisct_pkg::ANGLE_W-1:0]   angle,
    output logic                                   out_valid,
    output logic [1:0][tisct_pkg::POS_W-1:0]       pos
);
    import tisct_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0]          valid_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic [MAG_W-1:0]           mag_c_reg;
    logic [MAG_W-1:0]           mag_c_next;
    logic [ANGLE_W:0]           shifted_reg;
    logic [ANGLE_W:0]           shifted_next;
    logic [MAG_W-1:0]           mag_reg [2];
    logic [MAG_W-1:0]           mag_next [2];
    logic [PART_W-1:0]          plo_reg [2];
    logic [PART_W-1:0]          plo_next [2];
    logic [PART_W-1:0]          phi_reg [2];
    logic [PART_W-1:0]          phi_next [2];
    logic [POS_W-1:0]           pos_reg [2];
    logic [POS_W-1:0]           pos_next [2];
    logic [ANGLE_W:0]           angle_ext;
    logic [ANGLE_W:0]           angle_neg;
    logic [ANGLE_W:0]           shifted_neg;
    logic [PROD_W-1:0]          prod_sum [2];

    assign in_ready = adv || !valid_reg[0];

    // cosine lane takes the angle, sine lane takes the angle minus pi/2
    always_comb
    begin
        angle_ext = {angle_reg[ANGLE_W-1], angle_reg};
        angle_neg = -angle_ext;
        mag_c_next = angle_reg[ANGLE_W-1] ? angle_neg[MAG_W-1:0] : angle_ext[MAG_W-1:0];
        shifted_next = angle_ext - PI_HALF_Q26;

        shifted_neg = -shifted_reg;
        mag_next[0] = mag_c_reg;
        mag_next[1] = shifted_reg[ANGLE_W] ? shifted_neg[MAG_W-1:0] : shifted_reg[MAG_W-1:0];

        for (int l = 0; l < 2; l++)
        begin
            plo_next[l] = PART_W'(mag_reg[l]) * PART_W'(TWO_OVER_PI_Q64[HALF_W-1:0]);
            phi_next[l] = PART_W'(mag_reg[l]) * PART_W'(TWO_OVER_PI_Q64[COEF_W-1:HALF_W]);
            prod_sum[l] = PROD_W'(plo_reg[l]) + {phi_reg[l], {HALF_W{1'b0}}};
            pos_next[l] = prod_sum[l][PROD_W-1:POS_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg[STAGES-1:1] <= valid_reg[STAGES-2:0];
            end
            if (in_ready)
            begin
                valid_reg[0] <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            angle_reg <= angle;
        end
        if (adv)
        begin
            mag_c_reg <= mag_c_next;
            shifted_reg <= shifted_next;
            for (int l = 0; l < 2; l++)
            begin
                mag_reg[l] <= mag_next[l];
                plo_reg[l] <= plo_next[l];
                phi_reg[l] <= phi_next[l];
                pos_reg[l] <= pos_next[l];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign pos[0] = pos_reg[0];
    assign pos[1] = pos_reg[1];

endmodule

`default_nettype wire

// ===== hdl/tisct_interp.sv =====
`default_nettype none

module tisct_interp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [1:0][tisct_pkg::POS_W-1:0]   pos,
    output logic                               out_valid,
    output tisct_pkg::trig_t                   trig
);
    import tisct_pkg::*;

    localparam int STAGES = 3;
    localparam int MUL_W = VAL_W + FRACTION_BITS + 2;
    localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (FRACTION_BITS - 1);

    logic [STAGES-1:0]        valid_reg;
    logic [TABLE_BITS-1:0]    ti [2];
    logic                     mirror [2];
    logic [ROM_ADDR_W-1:0]    addr_a [2];
    logic [ROM_ADDR_W-1:0]    addr_b [2];
    logic [VAL_W-1:0]         va [2];
    logic [VAL_W-1:0]         vb [2];
    logic [VAL_W-1:0]         base_reg [2];
    logic [VAL_W-1:0]         base2_reg [2];
    logic signed [VAL_W:0]    slope_reg [2];
    logic signed [VAL_W:0]    slope_next [2];
    logic [FRACTION_BITS-1:0] frac_reg [2];
    logic                     neg_reg [2];
    logic                     neg2_reg [2];
    logic                     neg3_reg [2];
    logic signed [MUL_W-1:0]  prod_full [2];
    logic [MUL_W-1:0]         prod_reg [2];
    logic [MUL_W-1:0]         acc [2];
    logic [VAL_W-1:0]         mag_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ti[l] = pos[l][FRACTION_BITS +: TABLE_BITS];
            mirror[l] = pos[l][FRACTION_BITS + TABLE_BITS];
            if (mirror[l])
            begin
                addr_a[l] = ROM_ADDR_W'(TABLE_ENTRIES) - {1'b0, ti[l]};
                addr_b[l] = addr_a[l] - ROM_ADDR_W'(1);
            end
            else
            begin
                addr_a[l] = {1'b0, ti[l]};
                addr_b[l] = addr_a[l] + ROM_ADDR_W'(1);
            end
            va[l] = COS_ROM[addr_a[l]];
            vb[l] = COS_ROM[addr_b[l]];
            slope_next[l] = $signed({1'b0, vb[l]}) - $signed({1'b0, va[l]});

            prod_full[l] = slope_reg[l] * $signed({1'b0, frac_reg[l]});

            acc[l] = {2'b00, base2_reg[l], {FRACTION_BITS{1'b0}}} + prod_reg[l] + ROUND_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                base_reg[l] <= va[l];
                slope_reg[l] <= slope_next[l];
                frac_reg[l] <= pos[l][FRACTION_BITS-1:0];
                neg_reg[l] <= pos[l][FRACTION_BITS + TABLE_BITS]
                              ^ pos[l][FRACTION_BITS + TABLE_BITS + 1];

                base2_reg[l] <= base_reg[l];
                prod_reg[l] <= prod_full[l];
                neg2_reg[l] <= neg_reg[l];

                mag_reg[l] <= acc[l][FRACTION_BITS +: VAL_W];
                neg3_reg[l] <= neg2_reg[l];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign trig.mag_c = mag_reg[0];
    assign trig.neg_c = neg3_reg[0];
    assign trig.mag_s = mag_reg[1];
    assign trig.neg_s = neg3_reg[1];

endmodule

`default_nettype wire

// ===== hdl/tisct_divide.sv =====
`default_nettype none

module tisct_divide (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  tisct_pkg::trig_t                      trig,
    output logic                                  out_valid,
    output logic signed [tisct_pkg::OUT_W-1:0]    cosine,
    output logic signed [tisct_pkg::OUT_W-1:0]    sine,
    output logic signed [tisct_pkg::OUT_W-1:0]    tangent,
    output logic                                  tangent_saturated
);
    import tisct_pkg::*;

    localparam int NUM_W = VAL_W + TAN_FRAC;
    localparam int SAT_W = VAL_W + QUO_W;
    localparam int DEPTH = QUO_W + 1;

    typedef struct packed {
        logic [VAL_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic             sat;
        logic             tneg;
        trig_t            trig;
    } div_stage_t;

    logic [DEPTH:0]          valid_reg;
    div_stage_t              stage_reg [DEPTH];
    div_stage_t              stage_next [DEPTH];
    logic [NUM_W-1:0]        dividend;
    logic [VAL_W:0]          partial [QUO_W];
    logic [VAL_W:0]          reduced [QUO_W];
    logic                    take [QUO_W];
    div_stage_t              last;
    logic signed [OUT_W-1:0] cosine_reg;
    logic signed [OUT_W-1:0] cosine_next;
    logic signed [OUT_W-1:0] sine_reg;
    logic signed [OUT_W-1:0] sine_next;
    logic signed [OUT_W-1:0] tangent_reg;
    logic signed [OUT_W-1:0] tangent_next;
    logic                    saturated_reg;

    // restoring division, one quotient bit per stage
    always_comb
    begin
        dividend = {trig.mag_s, {TAN_FRAC{1'b0}}};
        stage_next[0].rem = VAL_W'(dividend[NUM_W-1:QUO_W]);
        stage_next[0].num = dividend[QUO_W-1:0];
        stage_next[0].sat = SAT_W'(dividend) >= {trig.mag_c, {QUO_W{1'b0}}};
        stage_next[0].tneg = (trig.neg_s && trig.mag_s != '0)
                             ^ (trig.neg_c && trig.mag_c != '0);
        stage_next[0].trig = trig;

        for (int j = 0; j < QUO_W; j++)
        begin
            partial[j] = {stage_reg[j].rem, stage_reg[j].num[QUO_W-1]};
            take[j] = partial[j] >= {1'b0, stage_reg[j].trig.mag_c};
            reduced[j] = partial[j] - {1'b0, stage_reg[j].trig.mag_c};
            stage_next[j+1] = stage_reg[j];
            stage_next[j+1].rem = take[j] ? reduced[j][VAL_W-1:0] : partial[j][VAL_W-1:0];
            stage_next[j+1].num = {stage_reg[j].num[QUO_W-2:0], take[j]};
        end

        last = stage_reg[DEPTH-1];
        if (last.sat)
        begin
            tangent_next = last.tneg ? -TAN_MAX : TAN_MAX;
        end
        else
        begin
            tangent_next = last.tneg ? -OUT_W'(last.num) : OUT_W'(last.num);
        end
        cosine_next = last.trig.neg_c ? -OUT_W'(last.trig.mag_c) : OUT_W'(last.trig.mag_c);
        sine_next = last.trig.neg_s ? -OUT_W'(last.trig.mag_s) : OUT_W'(last.trig.mag_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DEPTH-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            cosine_reg <= cosine_next;
            sine_reg <= sine_next;
            tangent_reg <= tangent_next;
            saturated_reg <= last.sat;
        end
    end

    assign out_valid = valid_reg[DEPTH];
    assign cosine = cosine_reg;
    assign sine = sine_reg;
    assign tangent = tangent_reg;
    assign tangent_saturated = saturated_reg;

endmodule

`default_nettype wire
